// ===== rtl/core/text_grid_escape_layout_assert.svh =====
// Assertion macros used by the text grid layout top level.
`ifndef TEXT_GRID_ESCAPE_LAYOUT_ASSERT_SVH
`define TEXT_GRID_ESCAPE_LAYOUT_ASSERT_SVH
`ifndef SYNTHESIS
// Combinational or implication property, checked on every clock out of reset.
`define TGEL_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("tgel assertion failed");
// Antecedent in one cycle, consequent in the next.
`define TGEL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tgel assertion failed");
`else
`define TGEL_ASSERT(label, prop)
`define TGEL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/tgel_pkg.sv =====
// Types, codes and constants of the text grid layout block.
package tgel_pkg;

    localparam int COLOUR_BITS = 16;
    localparam int COUNT_BITS  = 16;
    localparam int CP_BITS     = 21;
    localparam int LIMIT_BITS  = 17;
    localparam int CFG_BITS    = 21;
    localparam int IDX_BITS    = 3;
    localparam int OUT_TDATA_BITS = 88;

    // UTF-8 lead byte tags.
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    // Escape codes.
    localparam logic [7:0] ESC_NORMAL  = 8'h00;
    localparam logic [7:0] ESC_EMPH    = 8'h01;
    localparam logic [7:0] ESC_COLOUR  = 8'h02;
    localparam logic [7:0] ESC_SPECIAL = 8'h0F;
    localparam logic [7:0] ESC_FLAG    = 8'hE0;

    localparam logic [CP_BITS-1:0] CP_NEWLINE = CP_BITS'(10);

    typedef enum logic [IDX_BITS-1:0] {
        REG_ROWS     = 3'd0,
        REG_COLS     = 3'd1,
        REG_LIMIT    = 3'd2,
        REG_ESCAPE   = 3'd3,
        REG_START    = 3'd4,
        REG_NORMAL   = 3'd5,
        REG_EMPHASIS = 3'd6,
        REG_SPECIAL  = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_CONT1 = 4'd1,
        PH_CONT2 = 4'd2,
        PH_CONT3 = 4'd3,
        PH_ESC   = 4'd4,
        PH_COLHI = 4'd5,
        PH_COLLO = 4'd6,
        PH_KEY   = 4'd7,
        PH_VAL   = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        KIND_GLYPH = 2'd0,
        KIND_FLAG  = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_CONT  = 2'd0,
        ST_LIMIT = 2'd1,
        ST_END   = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]             grid_rows;
        logic [7:0]             grid_cols;
        logic [LIMIT_BITS-1:0]  char_limit;
        logic [CP_BITS-1:0]     escape_codepoint;
        logic [COLOUR_BITS-1:0] start_colour;
        logic [COLOUR_BITS-1:0] normal_colour;
        logic [COLOUR_BITS-1:0] emphasis_colour;
        logic [COLOUR_BITS-1:0] special_colour;
    } t_cfg;

    typedef struct packed {
        t_phase                 phase;
        logic [CP_BITS-1:0]     partial;
        logic [7:0]             esc_byte;
        logic [COLOUR_BITS-1:0] colour;
        logic [7:0]             col;
        logic [7:0]             row;
        logic [COUNT_BITS-1:0]  count;
        logic [7:0]             prev_flag_key;
        logic [7:0]             prev_flag_val;
        logic                   finished;
    } t_state;

    typedef struct packed {
        t_kind                  kind;
        logic [7:0]             cell_col;
        logic [7:0]             cell_row;
        logic [COLOUR_BITS-1:0] glyph_colour;
        logic [CP_BITS-1:0]     glyph_codepoint;
        logic [7:0]             flag_key;
        logic [7:0]             flag_value;
        t_status                end_status;
        logic [COUNT_BITS-1:0]  glyph_count;
    } t_result;

endpackage

// ===== rtl/core/tgel_cfg.sv =====
// Configuration register file of the text grid layout block.
module tgel_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [tgel_pkg::IDX_BITS-1:0] i_cfg_idx,
    input  logic [tgel_pkg::CFG_BITS-1:0] i_cfg_data,
    output tgel_pkg::t_cfg                o_cfg
);
    import tgel_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_rows        <= '0;
            r_cfg.grid_cols        <= '0;
            r_cfg.char_limit       <= '1;
            r_cfg.escape_codepoint <= CP_BITS'(27);
            r_cfg.start_colour     <= '0;
            r_cfg.normal_colour    <= '0;
            r_cfg.emphasis_colour  <= '0;
            r_cfg.special_colour   <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ROWS:     r_cfg.grid_rows        <= i_cfg_data[7:0];
                REG_COLS:     r_cfg.grid_cols        <= i_cfg_data[7:0];
                REG_LIMIT:    r_cfg.char_limit       <= i_cfg_data[LIMIT_BITS-1:0];
                REG_ESCAPE:   r_cfg.escape_codepoint <= i_cfg_data[CP_BITS-1:0];
                REG_START:    r_cfg.start_colour     <= i_cfg_data[COLOUR_BITS-1:0];
                REG_NORMAL:   r_cfg.normal_colour    <= i_cfg_data[COLOUR_BITS-1:0];
                REG_EMPHASIS: r_cfg.emphasis_colour  <= i_cfg_data[COLOUR_BITS-1:0];
                REG_SPECIAL:  r_cfg.special_colour   <= i_cfg_data[COLOUR_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/tgel_step.sv =====
// Per-byte decode, escape handling and grid placement logic.
module tgel_step (
    input  tgel_pkg::t_cfg    i_cfg,
    input  tgel_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_start,
    output tgel_pkg::t_state  o_state,
    output logic              o_res_valid,
    output tgel_pkg::t_result o_res
);
    import tgel_pkg::*;

    t_state                n;
    t_result               res;
    logic                  res_valid;
    logic                  stop;
    logic                  take;
    logic [CP_BITS-1:0]    take_cp;
    logic                  do_end;
    t_status               end_st;
    logic [CP_BITS-1:0]    part_next;
    logic [7:0]            col_old;
    logic [7:0]            row_old;
    logic                  last_row;
    logic                  last_col;
    logic                  at_limit;
    t_status               glyph_st;

    // Continuation bytes are only seen without a box start, so the held partial is current.
    assign part_next = {i_state.partial[CP_BITS-7:0], i_byte[5:0]};

    always_comb begin
        n         = i_state;
        res       = '0;
        res_valid = 1'b0;
        stop      = 1'b0;
        take      = 1'b0;
        take_cp   = '0;
        do_end    = 1'b0;
        end_st    = ST_END;
        col_old   = '0;
        row_old   = '0;
        at_limit  = 1'b0;
        glyph_st  = ST_CONT;

        // A box start clears the box state and may end the box at once.
        if (i_start) begin
            n.phase    = PH_IDLE;
            n.partial  = '0;
            n.esc_byte = '0;
            n.colour   = i_cfg.start_colour;
            n.col      = '0;
            n.row      = '0;
            n.count    = '0;
            n.finished = 1'b0;
            if (i_cfg.char_limit == '0) begin
                do_end = 1'b1;
                end_st = ST_LIMIT;
                stop   = 1'b1;
            end else if (i_cfg.grid_rows == '0 || i_cfg.grid_cols == '0) begin
                do_end = 1'b1;
                end_st = ST_END;
                stop   = 1'b1;
            end
        end

        // Cursor position of this item, before any advance.
        last_row = ({1'b0, n.row} + 9'd1) >= {1'b0, i_cfg.grid_rows};
        last_col = ({1'b0, n.col} + 9'd1) >= {1'b0, i_cfg.grid_cols};

        if (!stop && !n.finished) begin
            case (n.phase)
                PH_IDLE: begin
                    if (i_byte[7:5] == LEAD2_TAG) begin
                        n.partial = CP_BITS'(i_byte[4:0]);
                        n.phase   = PH_CONT1;
                    end else if (i_byte[7:4] == LEAD3_TAG) begin
                        n.partial = CP_BITS'(i_byte[3:0]);
                        n.phase   = PH_CONT2;
                    end else if (i_byte[7:3] == LEAD4_TAG) begin
                        n.partial = CP_BITS'(i_byte[2:0]);
                        n.phase   = PH_CONT3;
                    end else begin
                        take    = 1'b1;
                        take_cp = CP_BITS'(i_byte);
                    end
                end
                PH_CONT1, PH_CONT2, PH_CONT3: begin
                    if (i_byte == 8'd0) begin
                        do_end = 1'b1;
                        end_st = ST_END;
                    end else begin
                        n.partial = part_next;
                        if (n.phase == PH_CONT1) begin
                            n.phase = PH_IDLE;
                            take    = 1'b1;
                            take_cp = part_next;
                        end else if (n.phase == PH_CONT2) begin
                            n.phase = PH_CONT1;
                        end else begin
                            n.phase = PH_CONT2;
                        end
                    end
                end
                PH_ESC: begin
                    n.phase = PH_IDLE;
                    case (i_byte)
                        ESC_NORMAL:  n.colour = i_cfg.normal_colour;
                        ESC_EMPH:    n.colour = i_cfg.emphasis_colour;
                        ESC_SPECIAL: n.colour = i_cfg.special_colour;
                        ESC_COLOUR:  n.phase  = PH_COLHI;
                        ESC_FLAG:    n.phase  = PH_KEY;
                        default: ;
                    endcase
                end
                PH_COLHI: begin
                    n.esc_byte = i_byte;
                    n.phase    = PH_COLLO;
                end
                PH_COLLO: begin
                    n.colour = COLOUR_BITS'({n.esc_byte, i_byte});
                    n.phase  = PH_IDLE;
                end
                PH_KEY: begin
                    n.esc_byte = i_byte;
                    n.phase    = PH_VAL;
                end
                PH_VAL: begin
                    n.phase = PH_IDLE;
                    // A flag event that repeats the previous one is dropped.
                    if (!(n.esc_byte == n.prev_flag_key && i_byte == n.prev_flag_val)) begin
                        n.prev_flag_key  = n.esc_byte;
                        n.prev_flag_val  = i_byte;
                        res_valid        = 1'b1;
                        res.kind         = KIND_FLAG;
                        res.flag_key     = n.esc_byte;
                        res.flag_value   = i_byte;
                        res.end_status   = ST_CONT;
                        res.glyph_count  = n.count;
                    end
                end
                default: n.phase = PH_IDLE;
            endcase
        end

        // A complete codepoint: terminator, escape, newline or glyph.
        if (take) begin
            n.phase = PH_IDLE;
            if (take_cp == '0) begin
                do_end = 1'b1;
                end_st = ST_END;
            end else if (take_cp == i_cfg.escape_codepoint) begin
                n.phase = PH_ESC;
            end else if (take_cp == CP_NEWLINE) begin
                if (last_row) begin
                    do_end = 1'b1;
                    end_st = ST_END;
                end else begin
                    n.row = n.row + 8'd1;
                    n.col = '0;
                end
            end else begin
                col_old = n.col;
                row_old = n.row;
                if (n.count != '1) begin
                    n.count = n.count + COUNT_BITS'(1);
                end
                at_limit = !i_cfg.char_limit[LIMIT_BITS-1] && (i_cfg.char_limit != '0) &&
                           ({1'b0, n.count} >= i_cfg.char_limit);
                if (at_limit) begin
                    glyph_st = ST_LIMIT;
                end else if (last_col) begin
                    n.col = '0;
                    if (last_row) begin
                        glyph_st = ST_END;
                    end else begin
                        n.row = n.row + 8'd1;
                    end
                end else begin
                    n.col = n.col + 8'd1;
                end
                if (glyph_st != ST_CONT) begin
                    n.finished = 1'b1;
                end
                res_valid           = 1'b1;
                res.kind            = KIND_GLYPH;
                res.cell_col        = col_old;
                res.cell_row        = row_old;
                res.glyph_colour    = n.colour;
                res.glyph_codepoint = take_cp;
                res.end_status      = glyph_st;
                res.glyph_count     = n.count;
            end
        end

        if (do_end) begin
            n.finished      = 1'b1;
            n.phase         = PH_IDLE;
            res             = '0;
            res_valid       = 1'b1;
            res.kind        = KIND_END;
            res.end_status  = end_st;
            res.glyph_count = n.count;
        end
    end

    assign o_state     = n;
    assign o_res_valid = res_valid;
    assign o_res       = res;

endmodule

// ===== rtl/core/text_grid_escape_layout.sv =====
// Top level of the text grid layout block: input register, state, result register.
// Flow: a text byte accepted into the input register is processed against the box
// state once its result, if any, has room, and that result is then presented from
// the result register.
// Throughput: one byte per cycle while the result stream is not stalled.
// Reset (synchronous, active low) restores the register defaults and leaves the box finished.
`include "text_grid_escape_layout_assert.svh"

module text_grid_escape_layout (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_wr_en,
    input  logic [tgel_pkg::IDX_BITS-1:0]       i_cfg_idx,
    input  logic [tgel_pkg::CFG_BITS-1:0]       i_cfg_data,
    // Input stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // text_byte
    input  logic                                s_axis_tuser,   // box_start
    // Result stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // cell_col [7:0], cell_row [15:8], glyph_colour [31:16],
    // glyph_codepoint [52:32], flag_key [60:53], flag_value [68:61],
    // end_status [70:69], glyph_count [86:71], zero [87]
    output logic [tgel_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    output logic [1:0]                          m_axis_tuser    // kind
);
    import tgel_pkg::*;

    t_cfg    w_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result w_res;
    t_result r_out;
    logic    w_res_valid;
    logic    r_in_valid;
    logic    r_in_start;
    logic [7:0] r_in_byte;
    logic    r_out_valid;
    logic    w_fire;
    logic    w_in_take;

    tgel_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    tgel_step u_step (
        .i_cfg       (w_cfg),
        .i_state     (r_state),
        .i_byte      (r_in_byte),
        .i_start     (r_in_start),
        .o_state     (n_state),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // The held item is processed when its result, if any, has room: either
    // the result register is empty or is being drained this cycle. Items
    // that produce no result always go through.
    assign w_fire        = r_in_valid && (!w_res_valid || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
    end

    // Box state; the last flag key and value persist across boxes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, partial: '0, esc_byte: '0, colour: '0,
                         col: '0, row: '0, count: '0, prev_flag_key: '0,
                         prev_flag_val: '0, finished: 1'b1};
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {1'b0, r_out.glyph_count, r_out.end_status, r_out.flag_value,
                            r_out.flag_key, r_out.glyph_codepoint, r_out.glyph_colour,
                            r_out.cell_row, r_out.cell_col};

    // A finished box never carries a partial sequence.
    `TGEL_ASSERT(a_finished_idle, r_state.finished |-> r_state.phase == PH_IDLE)
    // With the box finished and no start, an item yields nothing.
    `TGEL_ASSERT(a_idle_silent, (w_fire && !r_in_start && r_state.finished) |-> !w_res_valid)
    // A result with a nonzero end status leaves the box finished.
    `TGEL_ASSERT_NEXT(a_end_finishes, (w_fire && w_res_valid && w_res.end_status != ST_CONT), r_state.finished)
    // The glyph count only grows within a box.
    `TGEL_ASSERT_NEXT(a_count_mono, (w_fire && !r_in_start), r_state.count >= $past(r_state.count))

endmodule

// ===== tb/text_grid_escape_layout_tb.sv =====
// Testbench for the text grid layout block: predicts every result item and checks the stream.
module text_grid_escape_layout_tb;
    import tgel_pkg::*;

    // One result item as the checker sees it, split into its fields.
    typedef struct {
        t_kind                  kind;
        logic [7:0]             col;
        logic [7:0]             row;
        logic [COLOUR_BITS-1:0] colour;
        logic [CP_BITS-1:0]     cp;
        logic [7:0]             key;
        logic [7:0]             value;
        t_status                status;
        logic [COUNT_BITS-1:0]  count;
    } t_layout_rec;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_wr_en = 1'b0;
    logic [IDX_BITS-1:0]       i_cfg_idx = '0;
    logic [CFG_BITS-1:0]       i_cfg_data = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata = '0;    // text_byte
    logic                      s_axis_tuser = 1'b0;  // box_start
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // cell_col, cell_row, glyph_colour, glyph_codepoint, flag_key, flag_value,
    // end_status, glyph_count, zero pad
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic [1:0]                m_axis_tuser;         // kind

    text_grid_escape_layout i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // Configuration as the block holds it; starts at the register reset values.
    int                     cfg_rows = 0;
    int                     cfg_cols = 0;
    int                     cfg_limit = -1;
    logic [CP_BITS-1:0]     cfg_esc = CP_BITS'(27);
    logic [COLOUR_BITS-1:0] cfg_start = '0;
    logic [COLOUR_BITS-1:0] cfg_normal = '0;
    logic [COLOUR_BITS-1:0] cfg_emph = '0;
    logic [COLOUR_BITS-1:0] cfg_special = '0;

    // Layout state of the predictor. The box is finished until the first box start.
    t_phase                 ph = PH_IDLE;
    logic [CP_BITS-1:0]     partial_cp = '0;
    logic [7:0]             esc_hold = '0;
    logic [COLOUR_BITS-1:0] cur_colour = '0;
    logic [7:0]             cur_col = '0;
    logic [7:0]             cur_row = '0;
    logic [COUNT_BITS-1:0]  placed = '0;
    logic [7:0]             prev_key = '0;
    logic [7:0]             prev_value = '0;
    bit                     box_done = 1'b1;

    t_layout_rec queued_layouts[$];   // predicted result items, oldest first
    int          mismatch_count = 0;
    int          active_bytes = 0;    // accepted bytes that the block did not ignore
    bit          no_idle = 1'b0;      // both sides run without gaps while set
    int          sink_wait = 0;

    function automatic string show(t_layout_rec r);
        return $sformatf("kind=%0d col=%0d row=%0d colour=%h cp=%h key=%h value=%h status=%0d count=%0d",
                         r.kind, r.col, r.row, r.colour, r.cp, r.key, r.value, r.status, r.count);
    endfunction

    function automatic void note_layout(t_kind k, logic [7:0] col, logic [7:0] row,
                                        logic [COLOUR_BITS-1:0] clr, logic [CP_BITS-1:0] cp,
                                        logic [7:0] key, logic [7:0] value, t_status st);
        t_layout_rec r;
        r.kind = k;
        r.col = col;
        r.row = row;
        r.colour = clr;
        r.cp = cp;
        r.key = key;
        r.value = value;
        r.status = st;
        r.count = placed;
        queued_layouts.push_back(r);
    endfunction

    function automatic void close_box(t_status st);
        box_done = 1'b1;
        ph = PH_IDLE;
        note_layout(KIND_END, '0, '0, '0, '0, '0, '0, st);
    endfunction

    // A fully decoded codepoint: terminator, escape, newline or a glyph on the grid.
    function automatic void place_codepoint(logic [CP_BITS-1:0] cp);
        logic [7:0] col;
        logic [7:0] row;
        t_status    st;
        ph = PH_IDLE;
        if (cp == '0) begin
            close_box(ST_END);
        end else if (cp == cfg_esc) begin
            ph = PH_ESC;
        end else if (cp == CP_NEWLINE) begin
            // A newline on the last row has nowhere to go and ends the box.
            if (int'(cur_row) + 1 >= cfg_rows) begin
                close_box(ST_END);
            end else begin
                cur_row++;
                cur_col = '0;
            end
        end else begin
            col = cur_col;
            row = cur_row;
            st = ST_CONT;
            if (placed != '1) placed++;
            // The limit wins over a full grid when both happen on the same glyph.
            if (cfg_limit > 0 && int'(placed) >= cfg_limit) begin
                st = ST_LIMIT;
            end else if (int'(cur_col) + 1 >= cfg_cols) begin
                cur_col = '0;
                if (int'(cur_row) + 1 >= cfg_rows) st = ST_END;
                else cur_row++;
            end else begin
                cur_col++;
            end
            if (st != ST_CONT) box_done = 1'b1;
            note_layout(KIND_GLYPH, col, row, cur_colour, cp, '0, '0, st);
        end
    endfunction

    // Advances the predicted layout by one accepted byte.
    function automatic void layout_predict_byte(logic [7:0] b, logic start);
        if (start) begin
            ph = PH_IDLE;
            partial_cp = '0;
            esc_hold = '0;
            cur_colour = cfg_start;
            cur_col = '0;
            cur_row = '0;
            placed = '0;
            box_done = 1'b0;
            // A zero limit or an empty grid ends the box before the byte is looked at.
            if (cfg_limit == 0) begin
                close_box(ST_LIMIT);
                return;
            end
            if (cfg_rows == 0 || cfg_cols == 0) begin
                close_box(ST_END);
                return;
            end
        end
        if (box_done) return;
        case (ph)
            PH_IDLE: begin
                if (b[7:5] == LEAD2_TAG) begin
                    partial_cp = CP_BITS'(b[4:0]);
                    ph = PH_CONT1;
                end else if (b[7:4] == LEAD3_TAG) begin
                    partial_cp = CP_BITS'(b[3:0]);
                    ph = PH_CONT2;
                end else if (b[7:3] == LEAD4_TAG) begin
                    partial_cp = CP_BITS'(b[2:0]);
                    ph = PH_CONT3;
                end else begin
                    // Plain ASCII, stray continuation bytes and invalid lead bytes are codepoints by themselves.
                    place_codepoint(CP_BITS'(b));
                end
            end
            PH_CONT1, PH_CONT2, PH_CONT3: begin
                if (b == 8'h00) begin
                    close_box(ST_END);
                end else begin
                    // Continuation bytes are not checked; only their low six bits count.
                    partial_cp = {partial_cp[CP_BITS-7:0], b[5:0]};
                    ph = t_phase'(ph - 4'd1);
                    if (ph == PH_IDLE) place_codepoint(partial_cp);
                end
            end
            PH_ESC: begin
                ph = PH_IDLE;
                case (b)
                    ESC_NORMAL:  cur_colour = cfg_normal;
                    ESC_EMPH:    cur_colour = cfg_emph;
                    ESC_SPECIAL: cur_colour = cfg_special;
                    ESC_COLOUR:  ph = PH_COLHI;
                    ESC_FLAG:    ph = PH_KEY;
                    default:     ;
                endcase
            end
            PH_COLHI: begin
                esc_hold = b;
                ph = PH_COLLO;
            end
            PH_COLLO: begin
                cur_colour = COLOUR_BITS'({esc_hold, b});
                ph = PH_IDLE;
            end
            PH_KEY: begin
                esc_hold = b;
                ph = PH_VAL;
            end
            PH_VAL: begin
                ph = PH_IDLE;
                // A flag event that repeats the last one is dropped.
                if (!(esc_hold == prev_key && b == prev_value)) begin
                    prev_key = esc_hold;
                    prev_value = b;
                    note_layout(KIND_FLAG, '0, '0, '0, '0, prev_key, prev_value, ST_CONT);
                end
            end
            default: ph = PH_IDLE;
        endcase
    endfunction

    // Sends one text byte after a random gap and predicts its effect once it is accepted.
    // The valid stays high after acceptance so that a gapless next item needs no toggle.
    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= start;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        if (start || !box_done) active_bytes++;
        layout_predict_byte(b, start);
    endtask

    function automatic logic [7:0] cont_byte(int unsigned v);
        // Mostly proper continuation bytes; now and then the tag bits are garbage,
        // which the decoder must tolerate.
        logic [1:0] tag;
        tag = ($urandom_range(0, 5) == 0) ? 2'($urandom) : 2'b10;
        return {tag, 6'(v)};
    endfunction

    // Sends a codepoint as UTF-8; the box start, if any, rides on the first byte.
    task automatic send_cp(input int unsigned cp, input logic start);
        logic [7:0] seq[$];
        if (cp < 'h80)
            seq = '{8'(cp)};
        else if (cp < 'h800)
            seq = '{8'hC0 | 8'(cp >> 6), cont_byte(cp)};
        else if (cp < 'h10000)
            seq = '{8'hE0 | 8'(cp >> 12), cont_byte(cp >> 6), cont_byte(cp)};
        else
            seq = '{8'hF0 | 8'(cp >> 18), cont_byte(cp >> 12), cont_byte(cp >> 6),
                    cont_byte(cp)};
        foreach (seq[i]) send_byte(seq[i], start && i == 0);
    endtask

    task automatic send_escape(input logic [7:0] code, input logic start);
        send_cp(cfg_esc, start);
        send_byte(code, 1'b0);
    endtask

    // Drops the input valid and waits until every predicted item has come out, then
    // waits on for bytes still in the pipeline that cause no result.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (queued_layouts.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_BITS-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    // Writes all eight registers while the block is idle.
    task automatic set_config(input int rows, input int cols, input int limit,
                              input int unsigned esc, input int unsigned start_clr,
                              input int unsigned normal_clr, input int unsigned emph_clr,
                              input int unsigned special_clr);
        wait_idle();
        write_reg(REG_ROWS, CFG_BITS'(rows & 'hFF));
        write_reg(REG_COLS, CFG_BITS'(cols & 'hFF));
        write_reg(REG_LIMIT, CFG_BITS'(limit & 'h1FFFF));
        write_reg(REG_ESCAPE, CFG_BITS'(esc));
        write_reg(REG_START, CFG_BITS'(start_clr & 'hFFFF));
        write_reg(REG_NORMAL, CFG_BITS'(normal_clr & 'hFFFF));
        write_reg(REG_EMPHASIS, CFG_BITS'(emph_clr & 'hFFFF));
        write_reg(REG_SPECIAL, CFG_BITS'(special_clr & 'hFFFF));
        i_cfg_wr_en <= 1'b0;
        cfg_rows = rows;
        cfg_cols = cols;
        cfg_limit = limit;
        cfg_esc = CP_BITS'(esc);
        cfg_start = COLOUR_BITS'(start_clr);
        cfg_normal = COLOUR_BITS'(normal_clr);
        cfg_emph = COLOUR_BITS'(emph_clr);
        cfg_special = COLOUR_BITS'(special_clr);
    endtask

    // With the reset register values the grid is empty: bytes outside a box are
    // ignored and a box start ends at once with the grid-full status.
    task automatic test_reset_state();
        send_byte("A", 1'b0);
        send_byte("A", 1'b1);
        send_byte("B", 1'b0);
    endtask

    // Two rows of four cells: one- to four-byte sequences, the largest codepoint,
    // stray bytes passing through, and a newline on the last row ending the box.
    task automatic test_glyph_decoding();
        set_config(2, 4, -1, 27, 'h1234, 'h0000, 'hFFFF, 'h00F0);
        send_byte("A", 1'b1);
        send_cp('h00E9, 1'b0);
        send_cp('h20AC, 1'b0);
        send_cp('h1FFFFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h0A, 1'b0);
    endtask

    // Every escape code, an ignored code, a zero code byte that must not terminate,
    // and flag events including repeats that are dropped.
    task automatic test_escape_codes();
        send_escape(ESC_EMPH, 1'b1);
        send_byte("a", 1'b0);
        send_escape(ESC_COLOUR, 1'b0);
        send_byte(8'hAB, 1'b0);
        send_byte(8'hCD, 1'b0);
        send_byte("b", 1'b0);
        send_escape(ESC_SPECIAL, 1'b0);
        send_escape(ESC_NORMAL, 1'b0);
        send_escape(8'h55, 1'b0);
        send_byte("c", 1'b0);
        // Key and value zero repeat the reset event and must be dropped.
        send_escape(ESC_FLAG, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        repeat (2) begin
            send_escape(ESC_FLAG, 1'b0);
            send_byte(8'h12, 1'b0);
            send_byte(8'h34, 1'b0);
        end
    endtask

    // Terminators: zero inside a sequence, an overlong zero, and a zero lead byte.
    task automatic test_terminators();
        send_byte("a", 1'b1);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hC0, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // Zero limit, limit and full grid on one glyph, full grid alone, the register
    // extremes, and an escape codepoint of zero that can never match.
    task automatic test_limits_and_extremes();
        set_config(1, 2, 0, 27, 0, 0, 0, 0);
        send_byte("a", 1'b1);
        set_config(1, 2, 2, 27, 0, 0, 0, 0);
        send_byte("a", 1'b1);
        send_byte("b", 1'b0);
        set_config(1, 2, 3, 27, 0, 0, 0, 0);
        send_byte("a", 1'b1);
        send_byte("b", 1'b0);
        set_config(255, 255, 65535, 'h1FFFFF, 'hFFFF, 'h0000, 'hFFFF, 'hFFFF);
        send_byte("a", 1'b1);
        send_escape(ESC_NORMAL, 1'b0);
        send_byte("b", 1'b0);
        send_byte(8'h0A, 1'b0);
        send_byte("c", 1'b0);
        set_config(3, 3, -1, 0, 'h00FF, 0, 0, 0);
        send_byte("a", 1'b1);
        send_byte(8'h00, 1'b0);
    endtask

    function automatic int pick_dim();
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return 255;
            2, 3:    return 1;
            default: return $urandom_range(2, 6);
        endcase
    endfunction

    // One random token: mostly well-formed text and escape sequences, some noise.
    task automatic send_random_token();
        logic start;
        int   pick;
        if (box_done) start = ($urandom_range(0, 15) != 0);
        else start = ($urandom_range(0, 59) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            send_byte(8'($urandom_range(32, 126)), start);
        end else if (pick < 50) begin
            send_byte(8'h0A, start);
        end else if (pick < 60) begin
            send_cp($urandom_range('h80, 'h7FF), start);
        end else if (pick < 65) begin
            send_cp($urandom_range('h800, 'hFFFF), start);
        end else if (pick < 68) begin
            send_cp($urandom_range('h10000, 'h1FFFFF), start);
        end else if (pick < 78) begin
            case ($urandom_range(0, 3))
                0: send_escape(ESC_NORMAL, start);
                1: send_escape(ESC_EMPH, start);
                2: send_escape(ESC_SPECIAL, start);
                default: send_escape(8'($urandom), start);
            endcase
        end else if (pick < 83) begin
            send_escape(ESC_COLOUR, start);
            send_byte(8'($urandom), 1'b0);
            send_byte(8'($urandom), 1'b0);
        end else if (pick < 90) begin
            // A small key and value set so that repeated events are common.
            send_escape(ESC_FLAG, start);
            send_byte(8'($urandom_range(0, 3)), 1'b0);
            send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)),
                      1'b0);
        end else if (pick < 93) begin
            send_byte(8'h00, start);
        end else if (pick < 96) begin
            send_byte($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hBF))
                                           : 8'($urandom_range('hF8, 'hFF)), start);
        end else begin
            send_byte(8'($urandom), start);
        end
    endtask

    // Phases of random text, each under a fresh random configuration and with
    // idling either on or off for both sides.
    task automatic test_random_layout(input int target);
        int goal;
        int limit;
        int unsigned esc;
        while (active_bytes < target) begin
            case ($urandom_range(0, 11))
                0:          limit = 0;
                1:          limit = 65535;
                2, 3, 4, 5: limit = -1;
                default:    limit = $urandom_range(1, 40);
            endcase
            case ($urandom_range(0, 7))
                0, 1, 2, 3: esc = 27;
                4:          esc = $urandom_range(32, 126);
                5:          esc = $urandom_range('h80, 'h7FF);
                6:          esc = $urandom_range('h800, 'h1FFFFF);
                default:    esc = $urandom_range(0, 1) ? 0 : $urandom_range(1, 31);
            endcase
            set_config(pick_dim(), pick_dim(), limit, esc, $urandom_range(0, 'hFFFF),
                       $urandom_range(0, 'hFFFF), $urandom_range(0, 'hFFFF),
                       $urandom_range(0, 'hFFFF));
            no_idle = ($urandom_range(0, 3) == 0);
            // Boxes that end at their start teach little, so such phases stay short.
            if (cfg_limit == 0 || cfg_rows == 0 || cfg_cols == 0)
                goal = active_bytes + 30;
            else
                goal = active_bytes + $urandom_range(120, 260);
            while (active_bytes < goal && active_bytes < target) send_random_token();
            no_idle = 1'b0;
        end
    endtask

    // Result side: random stalls, and every accepted item is compared field by field
    // with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_layout_rec seen;
        t_layout_rec want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            seen.kind = t_kind'(m_axis_tuser);
            seen.col = m_axis_tdata[7:0];
            seen.row = m_axis_tdata[15:8];
            seen.colour = m_axis_tdata[31:16];
            seen.cp = m_axis_tdata[52:32];
            seen.key = m_axis_tdata[60:53];
            seen.value = m_axis_tdata[68:61];
            seen.status = t_status'(m_axis_tdata[70:69]);
            seen.count = m_axis_tdata[86:71];
            if (queued_layouts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result item: %s", show(seen));
            end else begin
                want = queued_layouts.pop_front();
                if (seen.kind !== want.kind || seen.col !== want.col || seen.row !== want.row ||
                    seen.colour !== want.colour || seen.cp !== want.cp ||
                    seen.key !== want.key || seen.value !== want.value ||
                    seen.status !== want.status || seen.count !== want.count) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch\n  expected %s\n  actual   %s", show(want), show(seen));
                end
            end
            sink_wait = no_idle ? 0 : $urandom_range(0, 3);
        end else if (sink_wait > 0) begin
            sink_wait--;
        end
        m_axis_tready <= (sink_wait == 0);
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_glyph_decoding();
        test_escape_codes();
        test_terminators();
        test_limits_and_extremes();
        test_random_layout(active_bytes + 1750);
        wait_idle();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Far beyond the slowest correct run; a hang or a missing item ends here.
    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/tgel_pkg.sv
rtl/core/tgel_cfg.sv
rtl/core/tgel_step.sv
rtl/core/text_grid_escape_layout.sv
tb/text_grid_escape_layout_tb.sv
